// File: hw/rtl/amgs_pkg.sv
// Shared types and constants for the adjacency matrix graph store.
// No dependencies; imported by every module of the block.
package amgs_pkg;

   localparam int OPCODE_W = 4;
   localparam int VERT_W   = 4;
   localparam int WORD_W   = 32;
   localparam int LABEL_W  = 8;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_ADD_VERTEX   = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_LABEL    = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_GET_LABEL    = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_ADD_EDGE     = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_EDGE  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_SET_WEIGHT   = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_GET_WEIGHT   = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_EDGE_EXISTS  = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_FIRST_VERTEX = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_NEXT_VERTEX  = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_FIRST_ADJ    = 4'd10;
   localparam logic [OPCODE_W-1:0] OP_NEXT_ADJ     = 4'd11;
   localparam logic [OPCODE_W-1:0] OP_COUNT        = 4'd12;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic [VERT_W-1:0]        vertex_a;
      logic [VERT_W-1:0]        vertex_b;
      logic signed [WORD_W-1:0] weight_in;
      logic [LABEL_W-1:0]       label_in;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0]       index_out;
      logic                     found;
      logic [LABEL_W-1:0]       label_out;
      logic signed [WORD_W-1:0] weight_out;
      logic [COUNT_W-1:0]       count_out;
      logic                     table_full;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;   // clearing sweep step
      logic load;    // capture request word
      logic rd;      // memory read phase, first mirror write
      logic fin;     // second mirror write, result capture
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
   } ctl_sts_type;

endpackage

// File: hw/rtl/amgs_ctrl.sv
// Sequencer for the graph store: clearing sweep, read phase, finish phase.
// Depends on amgs_pkg; drives the datapath through ctl_cmd_type.
module amgs_ctrl
   import amgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   output ctl_cmd_type cmd,
   input  ctl_sts_type sts
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.fin   = 1'b1;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// File: hw/rtl/amgs_datapath.sv
// Datapath of the graph store: request register, vertex count, label,
// edge row and weight memories, adjacency scan. Depends on amgs_pkg.
module amgs_datapath
   import amgs_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  ctl_cmd_type  cmd,
   output ctl_sts_type  sts,
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);

   localparam int VIDX_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int WADDR_W = 2 * VIDX_W;
   localparam int RDEPTH  = 1 << VIDX_W;
   localparam int WDEPTH  = 1 << WADDR_W;
   localparam int CMP_W   = ((CNT_W > VERT_W) ? CNT_W : VERT_W) + 1;

   req_word_type              req_ff;
   rsp_word_type              rsp_ff, rsp_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [WADDR_W-1:0]        clear_cnt_ff;

   logic [LABEL_W-1:0]           label_mem  [RDEPTH];
   logic [MAX_VERTICES-1:0]      edge_mem   [RDEPTH];
   logic signed [WEIGHT_BITS-1:0] weight_mem [WDEPTH];

   logic [LABEL_W-1:0]            label_rd_ff;
   logic [MAX_VERTICES-1:0]       row_rd_ff;
   logic signed [WEIGHT_BITS-1:0] weight_rd_ff;

   logic [VIDX_W-1:0] a_idx, b_idx;
   logic [CMP_W-1:0]  a_ext, b_ext, total_ext, start_ext;
   logic              a_present, both_present, full;
   logic [OPCODE_W-1:0] op;

   // write ports
   logic                          wt_we;
   logic [WADDR_W-1:0]            wt_addr;
   logic signed [WEIGHT_BITS-1:0] wt_data;
   logic                          edge_we;
   logic [VIDX_W-1:0]             edge_row, edge_col;
   logic                          edge_bit;
   logic                          label_we;
   logic [VIDX_W-1:0]             label_addr;

   // scan
   logic [MAX_VERTICES-1:0] hit;
   logic [VIDX_W-1:0]       scan_idx;
   logic                    scan_found;

   assign op           = req_ff.opcode;
   assign a_idx        = VIDX_W'(req_ff.vertex_a);
   assign b_idx        = VIDX_W'(req_ff.vertex_b);
   assign a_ext        = CMP_W'(req_ff.vertex_a);
   assign b_ext        = CMP_W'(req_ff.vertex_b);
   assign total_ext    = CMP_W'(total_ff);
   assign a_present    = (a_ext < total_ext);
   assign both_present = a_present && (b_ext < total_ext);
   assign full         = (total_ff == CNT_W'(MAX_VERTICES));

   assign sts.clear_done = &clear_cnt_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         clear_cnt_ff <= '0;
      end else begin
         total_ff <= total_in;
         if (cmd.clear) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.fin && (op == OP_ADD_VERTEX) && !full) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.fin) begin
         rsp_ff <= rsp_in;
      end
   end

   // weight memory: one write port, one registered read
   always_comb begin
      wt_we   = 1'b0;
      wt_addr = {a_idx, b_idx};
      wt_data = WEIGHT_BITS'(req_ff.weight_in);
      if (cmd.clear) begin
         wt_we   = 1'b1;
         wt_addr = clear_cnt_ff;
         wt_data = '0;
      end else if (cmd.rd && both_present &&
                   ((op == OP_ADD_EDGE) || (op == OP_SET_WEIGHT))) begin
         wt_we = 1'b1;
      end else if (cmd.fin && both_present && (op == OP_ADD_EDGE)) begin
         wt_we   = 1'b1;
         wt_addr = {b_idx, a_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         weight_mem[wt_addr] <= wt_data;
      end
      if (cmd.rd) begin
         weight_rd_ff <= weight_mem[{a_idx, b_idx}];
      end
   end

   // edge row memory: row clear or single bit write, registered row read
   always_comb begin
      edge_we  = 1'b0;
      edge_row = a_idx;
      edge_col = b_idx;
      edge_bit = (op == OP_ADD_EDGE);
      if ((op == OP_ADD_EDGE) || (op == OP_REMOVE_EDGE)) begin
         if (cmd.rd && both_present) begin
            edge_we = 1'b1;
         end else if (cmd.fin && both_present) begin
            edge_we  = 1'b1;
            edge_row = b_idx;
            edge_col = a_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         edge_mem[clear_cnt_ff[WADDR_W-1 -: VIDX_W]] <= '0;
      end else if (edge_we) begin
         edge_mem[edge_row][edge_col] <= edge_bit;
      end
      if (cmd.rd) begin
         row_rd_ff <= edge_mem[a_idx];
      end
   end

   // label memory
   always_comb begin
      label_we   = 1'b0;
      label_addr = a_idx;
      if (cmd.fin) begin
         if ((op == OP_ADD_VERTEX) && !full) begin
            label_we   = 1'b1;
            label_addr = VIDX_W'(total_ff);
         end else if ((op == OP_SET_LABEL) && a_present) begin
            label_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (label_we) begin
         label_mem[label_addr] <= req_ff.label_in;
      end
      if (cmd.rd) begin
         label_rd_ff <= label_mem[a_idx];
      end
   end

   // lowest marked column in [start, total)
   assign start_ext = (op == OP_NEXT_ADJ) ? (b_ext + 1'b1) : '0;

   always_comb begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
         hit[c] = row_rd_ff[c] && (CMP_W'(c) >= start_ext) && (CMP_W'(c) < total_ext);
      end
   end

   always_comb begin
      scan_idx = '0;
      for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
         if (hit[c]) begin
            scan_idx = VIDX_W'(c);
         end
      end
      scan_found = |hit;
   end

   // result word
   always_comb begin
      rsp_in           = '0;
      rsp_in.count_out = COUNT_W'(total_in);
      unique case (op) inside
         OP_ADD_VERTEX: begin
            if (full) begin
               rsp_in.table_full = 1'b1;
            end else begin
               rsp_in.index_out = INDEX_W'(total_ff);
               rsp_in.found     = 1'b1;
            end
         end
         OP_GET_LABEL: begin
            if (a_present) begin
               rsp_in.label_out = label_rd_ff;
               rsp_in.found     = 1'b1;
            end
         end
         OP_GET_WEIGHT: begin
            if (both_present) begin
               rsp_in.weight_out = WORD_W'(weight_rd_ff);
               rsp_in.found      = 1'b1;
            end
         end
         OP_EDGE_EXISTS: begin
            rsp_in.found = both_present && row_rd_ff[b_idx];
         end
         OP_FIRST_VERTEX: begin
            rsp_in.found = (total_ff != '0);
         end
         OP_NEXT_VERTEX: begin
            if ((a_ext + 1'b1) < total_ext) begin
               rsp_in.index_out = req_ff.vertex_a + 1'b1;
               rsp_in.found     = 1'b1;
            end
         end
         OP_FIRST_ADJ, OP_NEXT_ADJ: begin
            if (a_present && scan_found) begin
               rsp_in.index_out = INDEX_W'(scan_idx);
               rsp_in.found     = 1'b1;
            end
         end
         default: begin
            rsp_in.found = 1'b0;
         end
      endcase
   end

   assign rsp_word = rsp_ff;

endmodule

// File: hw/rtl/adjacency_matrix_graph_store_core.sv
// Top level of the adjacency matrix graph store.
// Depends on amgs_pkg, amgs_ctrl and amgs_datapath.
//
// Weighted undirected graph held as an adjacency matrix: vertex count, one
// label per vertex, an edge-present bit matrix and a weight matrix. A request
// word is taken at a rising edge where start is high and busy is low; busy
// then stays high through a read state on the label, edge row and weight
// memories, then a finish state that does the mirror write of an edge and
// the priority encode of an adjacency scan.
// Every request gives exactly one response word, shown on rsp_word for one
// cycle with rsp_strobe high, in the cycle after the finish state. The
// receiver cannot hold off a response: it must take it in that cycle. A new
// request may be issued in the same cycle the strobe is up, but none is
// taken while busy is high. After reset the block sweeps the weight memory
// (and the edge rows along with it) to zero, one entry a cycle, holding busy
// high until 2**(2*clog2(MAX_VERTICES)) entries, 256 by default, are zeroed.
// Labels are not cleared; a label is always written when its vertex is added.
module adjacency_matrix_graph_store_core
   import amgs_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // state machine: clear sweep, idle, read, finish
   amgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   // memories, vertex count, scan and result assembly
   amgs_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule
